@@ sv/p2b_pkg.sv @@
// ----------------------------------------------------------------------------
// p2b_pkg
// Shared constants, widths and types for the PIN entry to PIN block converter.
// ----------------------------------------------------------------------------
`default_nettype none

package p2b_pkg;

  localparam int LINE_BYTES    = 16;
  localparam int MAX_DIGITS    = 12;
  localparam int MIN_DIGITS    = 4;
  localparam int BLOCK_NIBBLES = 14;
  localparam int BLOCK_BYTES   = BLOCK_NIBBLES / 2 + 1;
  localparam int QUEUE_DEPTH   = 2;

  localparam int BYTES_W    = $clog2(LINE_BYTES + 1);
  localparam int CNT_W      = $clog2(MAX_DIGITS + 2);
  localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
  localparam int NIB_POS_W  = $clog2(BLOCK_NIBBLES);
  localparam int OUT_IDX_W  = $clog2(BLOCK_BYTES);
  localparam int Q_IDX_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_CNT_W    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] LEN_TAG    = 8'h20;
  localparam logic [3:0] PAD_NIBBLE = 4'hF;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_VT    = 8'h0B;

  typedef logic [MAX_DIGITS-1:0][3:0] digits_t;

  // one judged entry handed from the parser to the block emitter
  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] len;
    digits_t          digits;
  } job_t;

  function automatic logic [3:0] nibble_at(input digits_t d,
                                           input logic [CNT_W-1:0] len,
                                           input logic [NIB_POS_W-1:0] pos);
    logic [3:0] r;
    r = PAD_NIBBLE;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (NIB_POS_W'(i) == pos && CNT_W'(i) < len) begin
        r = d[i];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/p2b_front.sv @@
// ----------------------------------------------------------------------------
// p2b_front
// Per-byte PIN line parser; judges the entry on the end-of-line byte.
// ----------------------------------------------------------------------------
`default_nettype none

module p2b_front
  import p2b_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_line,
  input  wire logic       q_full,
  output logic            q_push,
  output job_t            q_data
);

  localparam logic [1:0] PH_LEAD   = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_TRAIL  = 2'd2;
  localparam logic [1:0] PH_BAD    = 2'd3;

  logic [1:0]         parse_phase, parse_phase_next;
  logic [CNT_W-1:0]   digit_count, digit_count_next;
  logic [BYTES_W-1:0] bytes_seen, bytes_seen_next;
  logic               string_ended, string_ended_next;
  digits_t            digit_store;
  digits_t            digits_cur;
  logic               accept;
  logic               take;
  logic               is_digit;
  logic               is_blank;
  logic               digit_we;
  logic [3:0]         digit_val;
  logic [DIG_IDX_W-1:0] digit_idx;

  assign in_stall  = in_valid && end_of_line && q_full;
  assign accept    = in_valid && !in_stall;
  assign take      = (bytes_seen < BYTES_W'(LINE_BYTES)) && !string_ended;
  assign is_digit  = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
  assign is_blank  = (in_byte == CHAR_LF) || (in_byte == CHAR_CR) || (in_byte == CHAR_SP) ||
                     (in_byte == CHAR_TAB) || (in_byte == CHAR_VT);
  assign digit_val = in_byte[3:0] - CHAR_ZERO[3:0];
  assign digit_idx = digit_count[DIG_IDX_W-1:0];

  always_comb begin
    parse_phase_next  = parse_phase;
    digit_count_next  = digit_count;
    bytes_seen_next   = bytes_seen;
    string_ended_next = string_ended;
    digit_we          = 1'b0;
    if (take) begin
      bytes_seen_next = bytes_seen + BYTES_W'(1);
      if (in_byte == CHAR_NUL) begin
        string_ended_next = 1'b1;
      end else if (parse_phase != PH_BAD) begin
        if (is_blank) begin
          if (parse_phase == PH_DIGITS) begin
            parse_phase_next = PH_TRAIL;
          end
        end else if (is_digit && (parse_phase == PH_LEAD || parse_phase == PH_DIGITS)) begin
          parse_phase_next = PH_DIGITS;
          if (digit_count < CNT_W'(MAX_DIGITS)) begin
            digit_we         = 1'b1;
            digit_count_next = digit_count + CNT_W'(1);
          end else begin
            digit_count_next = CNT_W'(MAX_DIGITS + 1);
          end
        end else begin
          parse_phase_next = PH_BAD;
        end
      end
    end
  end

  // store contents including the byte now being taken
  always_comb begin
    digits_cur = digit_store;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (digit_we && digit_idx == DIG_IDX_W'(i)) begin
        digits_cur[i] = digit_val;
      end
    end
  end

  assign q_push        = accept && end_of_line;
  assign q_data.ok     = (parse_phase_next != PH_BAD) &&
                         (digit_count_next >= CNT_W'(MIN_DIGITS)) &&
                         (digit_count_next <= CNT_W'(MAX_DIGITS));
  assign q_data.len    = digit_count_next;
  assign q_data.digits = digits_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase  <= PH_LEAD;
      digit_count  <= '0;
      bytes_seen   <= '0;
      string_ended <= 1'b0;
    end else if (accept) begin
      if (end_of_line) begin
        parse_phase  <= PH_LEAD;
        digit_count  <= '0;
        bytes_seen   <= '0;
        string_ended <= 1'b0;
      end else begin
        parse_phase  <= parse_phase_next;
        digit_count  <= digit_count_next;
        bytes_seen   <= bytes_seen_next;
        string_ended <= string_ended_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && digit_we) begin
      digit_store[digit_idx] <= digit_val;
    end
  end

endmodule

`default_nettype wire

@@ sv/p2b_queue.sv @@
// ----------------------------------------------------------------------------
// p2b_queue
// Short FIFO of judged entries between the parser and the block emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module p2b_queue
  import p2b_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      push_data,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output job_t      head
);

  job_t               entries [QUEUE_DEPTH];
  logic [Q_IDX_W-1:0] wptr;
  logic [Q_IDX_W-1:0] rptr;
  logic [Q_CNT_W-1:0] count;

  assign full      = (count == Q_CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + Q_IDX_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + Q_IDX_W'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ sv/p2b_back.sv @@
// ----------------------------------------------------------------------------
// p2b_back
// Emits the PIN block bytes, or one reject, for each queued entry.
// ----------------------------------------------------------------------------
`default_nettype none

module p2b_back
  import p2b_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_not_empty,
  input  job_t      q_head,
  output logic      q_pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic [7:0] block_byte,
  output logic       status,
  output logic       last_of_run
);

  logic [OUT_IDX_W-1:0] idx;
  logic                 load;
  logic                 fire;
  logic                 done;
  logic [7:0]           res_byte;
  logic                 res_status;
  logic [NIB_POS_W-1:0] pos_hi;
  logic [NIB_POS_W-1:0] pos_lo;

  assign load   = !out_valid || !out_stall;
  assign fire   = load && q_not_empty;
  assign pos_hi = NIB_POS_W'({idx - OUT_IDX_W'(1), 1'b0});
  assign pos_lo = pos_hi | NIB_POS_W'(1);

  always_comb begin
    if (!q_head.ok) begin
      res_byte   = '0;
      res_status = 1'b1;
      done       = 1'b1;
    end else begin
      res_status = 1'b0;
      done       = (idx == OUT_IDX_W'(BLOCK_BYTES - 1));
      if (idx == '0) begin
        res_byte = LEN_TAG | 8'(q_head.len);
      end else begin
        res_byte = {nibble_at(q_head.digits, q_head.len, pos_hi),
                    nibble_at(q_head.digits, q_head.len, pos_lo)};
      end
    end
  end

  assign q_pop = fire && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= q_not_empty;
      if (q_not_empty) begin
        idx <= done ? '0 : idx + OUT_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      block_byte  <= res_byte;
      status      <= res_status;
      last_of_run <= done;
    end
  end

endmodule

`default_nettype wire

@@ sv/pin_entry_to_pin_block.sv @@
// ----------------------------------------------------------------------------
// pin_entry_to_pin_block
// PIN entry line to format-2 PIN block converter, one character per cycle.
// ----------------------------------------------------------------------------
// end-of-line queues the judged entry; results are registered from the queue head
// throughput: 1 byte in per cycle; 1 result per unstalled cycle (8 per good entry)
// a two-entry queue decouples the parser from the emitter; the input stalls only
// on an end-of-line byte while that queue is full
// reset: synchronous; parser, queue and output return to empty, digits not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module pin_entry_to_pin_block
  import p2b_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_line,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      block_byte,
  output logic            status,
  output logic            last_of_run
);

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_not_empty;
  job_t q_data;
  job_t q_head;

  p2b_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .end_of_line (end_of_line),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_data)
  );

  p2b_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  p2b_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .block_byte  (block_byte),
    .status      (status),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

@@ sv/p2b_checker.sv @@
// ----------------------------------------------------------------------------
// p2b_checker
// Port-level checks for the PIN block converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module p2b_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       end_of_line,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] block_byte,
  input wire logic       status,
  input wire logic       last_of_run
);

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(block_byte) &&
                               $stable(status) && $stable(last_of_run))
    else $error("output transaction changed while stalled");

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // reject is a single closing result with a zero byte
  a_reject_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> last_of_run && block_byte == 8'h00)
    else $error("malformed reject result");

  // only an end-of-line transaction can be held back
  a_stall_eol: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_valid && end_of_line)
    else $error("input stalled on a mid-line byte");

  // the first result after a closing one carries the length tag or a reject
  a_first_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_of_run ##1 out_valid && !status |->
      block_byte[7:4] == 4'h2)
    else $error("block does not start with the length byte");

endmodule

bind pin_entry_to_pin_block p2b_checker u_p2b_checker (.*);

`default_nettype wire
